@@ hw/rtl/rpn_operand_stack_macros.svh @@
// ---------------------------------------------------------------------------
// rpn_operand_stack_macros.svh
// Assertion macros for the operand stack RTL.
// ---------------------------------------------------------------------------
`ifndef RPN_OPERAND_STACK_MACROS_SVH
`define RPN_OPERAND_STACK_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define RPNOS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define RPNOS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rpnos_pkg.sv @@
// ---------------------------------------------------------------------------
// rpnos_pkg
// Types and codes for the reverse-Polish operand stack.
// ---------------------------------------------------------------------------
package rpnos_pkg;

    typedef enum logic [3:0] {
        OP_PEEK     = 4'd0,
        OP_PUSH     = 4'd1,
        OP_POP      = 4'd2,
        OP_DUP      = 4'd3,
        OP_DROP     = 4'd4,
        OP_SWAP     = 4'd5,
        OP_OVER     = 4'd6,
        OP_ROT      = 4'd7,
        OP_ROLLUP   = 4'd8,
        OP_ROLLDOWN = 4'd9,
        OP_PICK     = 4'd10
    } t_op;

    // What a stack cell loads on an update.
    typedef enum logic [1:0] {
        MV_HOLD      = 2'd0,
        MV_FROM_UP   = 2'd1,
        MV_FROM_DOWN = 2'd2,
        MV_LOAD      = 2'd3
    } t_move;

    typedef struct packed {
        logic [3:0]  operation;
        logic [63:0] push_word;
        logic [5:0]  level;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [63:0] read_word;
        logic        word_defined;
        logic [5:0]  stack_count;
    } t_out_item;

    // Per-operation cell moves, decoded once for the whole row.
    typedef struct packed {
        t_move m0;
        t_move m1;
        t_move m2;
        t_move mrest;
        logic  bot_load;
        logic  load_push;
    } t_plan;

endpackage

@@ hw/rtl/rpnos_cell.sv @@
// ---------------------------------------------------------------------------
// rpnos_cell
// One stack level: holds a word and takes it from a neighbor or a load bus.
// ---------------------------------------------------------------------------
module rpnos_cell #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  rpnos_pkg::t_move     i_move,
    input  logic [WORD_BITS-1:0] i_up_word,
    input  logic [WORD_BITS-1:0] i_down_word,
    input  logic [WORD_BITS-1:0] i_load_word,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        unique case (i_move)
            rpnos_pkg::MV_HOLD:      n_word = r_word;
            rpnos_pkg::MV_FROM_UP:   n_word = i_up_word;
            rpnos_pkg::MV_FROM_DOWN: n_word = i_down_word;
            rpnos_pkg::MV_LOAD:      n_word = i_load_word;
            default:                 n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ hw/rtl/rpn_operand_stack.sv @@
// A result is registered: it is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while the consumer takes results, rolls
// included; every cell shifts from a neighbor or loads a word in the same
// cycle, and the result register decouples a stalled consumer for one item.
// Reset (synchronous, active low) clears the depth and the result valid;
// stack words are not cleared.
// ---------------------------------------------------------------------------
// rpn_operand_stack
// Bounded operand stack built as a row of cells, level 1 (top) in cell 0.
// ---------------------------------------------------------------------------
`include "rpn_operand_stack_macros.svh"

module rpn_operand_stack #(
    parameter int CAPACITY  = 32,
    parameter int WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rpnos_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rpnos_pkg::t_out_item  o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = (CW > 6) ? CW : 6;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    rpnos_pkg::t_out_item  r_out;

    logic [WORD_BITS-1:0]  w_cell [CAPACITY];
    logic [WORD_BITS-1:0]  sel_word;
    logic [WORD_BITS-1:0]  top_load;
    logic [WORD_BITS-1:0]  push_w;
    logic [IW-1:0]         sel_idx;
    logic [IW-1:0]         bot_idx;
    logic [XW-1:0]         lvl_x;
    logic [XW-1:0]         cnt_x;
    logic                  lvl_ok;
    logic                  full;
    logic                  in_acc;
    logic                  cell_en;
    logic                  n_ok;
    logic                  n_defd;
    logic [WORD_BITS-1:0]  n_rd;
    rpnos_pkg::t_plan      plan;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign lvl_x   = XW'(i_in_item.level);
    assign cnt_x   = XW'(r_count);
    assign lvl_ok  = (lvl_x != '0) && (lvl_x <= cnt_x);
    assign full    = (r_count >= CW'(CAPACITY));
    assign push_w  = i_in_item.push_word[WORD_BITS-1:0];
    assign bot_idx = IW'(r_count - CW'(1));

    // Decode the operation into checks, new depth and cell moves.
    always_comb begin
        n_ok      = 1'b0;
        n_defd    = 1'b0;
        n_rd      = '0;
        n_count   = r_count;
        sel_idx   = IW'(lvl_x - XW'(1));
        plan      = '{m0: rpnos_pkg::MV_HOLD, m1: rpnos_pkg::MV_HOLD,
                      m2: rpnos_pkg::MV_HOLD, mrest: rpnos_pkg::MV_HOLD,
                      bot_load: 1'b0, load_push: 1'b0};
        unique case (rpnos_pkg::t_op'(i_in_item.operation)) inside
            rpnos_pkg::OP_PEEK: begin
                if (lvl_ok) begin
                    n_ok   = 1'b1;
                    n_defd = 1'b1;
                    n_rd   = sel_word;
                end
            end
            rpnos_pkg::OP_PUSH: begin
                n_ok           = !full;
                n_count        = r_count + CW'(1);
                plan.m0        = rpnos_pkg::MV_LOAD;
                plan.load_push = 1'b1;
                plan.m1        = rpnos_pkg::MV_FROM_UP;
                plan.m2        = rpnos_pkg::MV_FROM_UP;
                plan.mrest     = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_POP, rpnos_pkg::OP_DROP: begin
                if (r_count != '0) begin
                    n_ok = 1'b1;
                    if (rpnos_pkg::t_op'(i_in_item.operation) == rpnos_pkg::OP_POP) begin
                        n_defd = 1'b1;
                        n_rd   = w_cell[0];
                    end
                end
                n_count    = r_count - CW'(1);
                plan.m0    = rpnos_pkg::MV_FROM_DOWN;
                plan.m1    = rpnos_pkg::MV_FROM_DOWN;
                plan.m2    = rpnos_pkg::MV_FROM_DOWN;
                plan.mrest = rpnos_pkg::MV_FROM_DOWN;
            end
            rpnos_pkg::OP_DUP: begin
                n_ok       = (r_count != '0) && !full;
                n_count    = r_count + CW'(1);
                plan.m1    = rpnos_pkg::MV_FROM_UP;
                plan.m2    = rpnos_pkg::MV_FROM_UP;
                plan.mrest = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_SWAP: begin
                n_ok    = (r_count >= CW'(2));
                plan.m0 = rpnos_pkg::MV_FROM_DOWN;
                plan.m1 = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_OVER: begin
                n_ok       = (r_count >= CW'(2)) && !full;
                n_count    = r_count + CW'(1);
                plan.m0    = rpnos_pkg::MV_FROM_DOWN;
                plan.m1    = rpnos_pkg::MV_FROM_UP;
                plan.m2    = rpnos_pkg::MV_FROM_UP;
                plan.mrest = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_ROT: begin
                // Third level goes to the top, the top two move down one.
                n_ok    = (r_count >= CW'(3));
                sel_idx = IW'(2);
                plan.m0 = rpnos_pkg::MV_LOAD;
                plan.m1 = rpnos_pkg::MV_FROM_UP;
                plan.m2 = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_ROLLUP: begin
                // Shift toward the top; the bottom cell takes the old top.
                n_ok          = (r_count >= CW'(2));
                plan.m0       = rpnos_pkg::MV_FROM_DOWN;
                plan.m1       = rpnos_pkg::MV_FROM_DOWN;
                plan.m2       = rpnos_pkg::MV_FROM_DOWN;
                plan.mrest    = rpnos_pkg::MV_FROM_DOWN;
                plan.bot_load = 1'b1;
            end
            rpnos_pkg::OP_ROLLDOWN: begin
                n_ok       = (r_count >= CW'(2));
                sel_idx    = bot_idx;
                plan.m0    = rpnos_pkg::MV_LOAD;
                plan.m1    = rpnos_pkg::MV_FROM_UP;
                plan.m2    = rpnos_pkg::MV_FROM_UP;
                plan.mrest = rpnos_pkg::MV_FROM_UP;
            end
            rpnos_pkg::OP_PICK: begin
                n_ok       = lvl_ok && !full;
                n_count    = r_count + CW'(1);
                plan.m0    = rpnos_pkg::MV_LOAD;
                plan.m1    = rpnos_pkg::MV_FROM_UP;
                plan.m2    = rpnos_pkg::MV_FROM_UP;
                plan.mrest = rpnos_pkg::MV_FROM_UP;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        // Refused: leave the depth as it was.
        if (!n_ok) begin
            n_count = r_count;
        end
    end

    assign sel_word = w_cell[sel_idx];
    assign top_load = plan.load_push ? push_w : sel_word;
    assign cell_en  = in_acc && n_ok;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] up_w;
        logic [WORD_BITS-1:0] down_w;
        logic [WORD_BITS-1:0] load_w;
        rpnos_pkg::t_move     move;
        rpnos_pkg::t_move     base_move;

        if (i == 0) begin : g_first
            assign up_w      = w_cell[0];
            assign load_w    = top_load;
            assign base_move = plan.m0;
        end else begin : g_other
            assign up_w      = w_cell[i-1];
            assign load_w    = w_cell[0];
            if (i == 1) begin : g_second
                assign base_move = plan.m1;
            end else if (i == 2) begin : g_third
                assign base_move = plan.m2;
            end else begin : g_rest
                assign base_move = plan.mrest;
            end
        end

        if (i == CAPACITY - 1) begin : g_last
            assign down_w = w_cell[i];
        end else begin : g_inner
            assign down_w = w_cell[i+1];
        end

        assign move = (plan.bot_load && (bot_idx == IW'(i))) ? rpnos_pkg::MV_LOAD
                                                             : base_move;

        rpnos_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_en        (cell_en),
            .i_move      (move),
            .i_up_word   (up_w),
            .i_down_word (down_w),
            .i_load_word (load_w),
            .o_word      (w_cell[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.ok           <= n_ok;
            r_out.read_word    <= 64'(n_rd);
            r_out.word_defined <= n_defd;
            r_out.stack_count  <= 6'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `RPNOS_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= CW'(CAPACITY), "depth above capacity")
    `RPNOS_ASSERT_NEXT(a_result_follows, in_acc, r_out_valid, "accepted item gave no result")
    `RPNOS_ASSERT_NEXT(a_refused_holds, in_acc && !n_ok,
                       r_count == $past(r_count), "refused op moved depth")
    `RPNOS_ASSERT_NOW(a_defined_is_ok, r_out_valid && r_out.word_defined,
                      r_out.ok, "defined word on refused op")

endmodule
